[rtl/rpe_pkg.sv]
// Package for the rotary position embedding pipeline.
// Holds the fixed-point angle constants, pipeline widths and the CORDIC arctangent table.
// No dependencies.
package rpe_pkg;

	localparam int ProdW    = 48;
	localparam int AngW     = 35;
	localparam int RedSteps = 15;

	localparam logic [ProdW-1:0]       TwoPiQ31  = 48'd13493037705;
	localparam logic signed [AngW-1:0] TwoPiQ30  = 35'sd6746518852;
	localparam logic signed [AngW-1:0] PiQ30     = 35'sd3373259426;
	localparam logic signed [AngW-1:0] HalfPiQ30 = 35'sd1686629713;
	localparam logic signed [AngW-1:0] GainQ30   = 35'sd652032874;

	function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] idx);
		logic signed [AngW-1:0] v;
		case (idx)
			5'd0:  v = 35'sh3243F6A8;
			5'd1:  v = 35'sh1DAC6705;
			5'd2:  v = 35'sh0FADBAFC;
			5'd3:  v = 35'sh07F56EA6;
			5'd4:  v = 35'sh03FEAB76;
			5'd5:  v = 35'sh01FFD55B;
			5'd6:  v = 35'sh00FFFAAA;
			5'd7:  v = 35'sh007FFF55;
			5'd8:  v = 35'sh003FFFEA;
			5'd9:  v = 35'sh001FFFFD;
			5'd10: v = 35'sh000FFFFF;
			5'd11: v = 35'sh0007FFFF;
			5'd12: v = 35'sh0003FFFF;
			5'd13: v = 35'sh0001FFFF;
			5'd14: v = 35'sh0000FFFF;
			5'd15: v = 35'sh00007FFF;
			5'd16: v = 35'sh00003FFF;
			5'd17: v = 35'sh00001FFF;
			5'd18: v = 35'sh00000FFF;
			5'd19: v = 35'sh000007FF;
			5'd20: v = 35'sh000003FF;
			5'd21: v = 35'sh000001FF;
			5'd22: v = 35'sh000000FF;
			5'd23: v = 35'sh0000007F;
			5'd24: v = 35'sh0000003F;
			5'd25: v = 35'sh0000001F;
			5'd26: v = 35'sh0000000F;
			5'd27: v = 35'sh00000008;
			5'd28: v = 35'sh00000004;
			5'd29: v = 35'sh00000002;
			5'd30: v = 35'sh00000001;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/rotary_position_embedding.sv]
// Rotary position embedding: top level, one rotation pair per item.
// Depends on rpe_pkg.
//
// Fully pipelined: one item enters per clock while in_stall is low, and each item
// passes CORDIC_STAGES + 20 register stages. The stages are one multiply stage for
// the angle, fifteen compare-subtract stages for the reduction modulo 2*pi, one fold
// stage, one CORDIC rotation per stage, and multiply, sum and round/saturate stages.
// The whole pipe advances together; in_stall rises only while the final result is
// held by out_stall.
module rotary_position_embedding #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        position,
	input  logic [31:0]        frequency,
	input  logic signed [31:0] x_left,
	input  logic signed [31:0] x_right,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_left,
	output logic signed [31:0] out_right
);

	localparam int NC      = CORDIC_STAGES;
	localparam int FoldIdx = rpe_pkg::RedSteps + 1;
	localparam int MulIdx  = FoldIdx + NC + 1;
	localparam int Depth   = MulIdx + 3;
	localparam int AW      = rpe_pkg::AngW;
	localparam int PW      = 32 + AW;

	logic en;
	logic vld_s [Depth];

	logic [rpe_pkg::ProdW-1:0] red_s [0:rpe_pkg::RedSteps];
	logic signed [31:0] xl_s [MulIdx];
	logic signed [31:0] xr_s [MulIdx];

	logic signed [AW-1:0] z_s [0:NC];
	logic                 flip_s [0:NC];
	logic signed [AW-1:0] x_s [1:NC];
	logic signed [AW-1:0] y_s [1:NC];

	logic signed [PW-1:0] pll_s, prs_s, prc_s, pls_s;
	logic signed [PW:0]   accl_s, accr_s;
	logic signed [31:0]   outl_s, outr_s;

	assign en       = !(vld_s[Depth-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_s[Depth-1];
	assign out_left  = outl_s;
	assign out_right = outr_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < Depth; j++) vld_s[j] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int j = 1; j < Depth; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	// operand carry up to the output multipliers
	always_ff @(posedge clk) begin
		if (en) begin
			xl_s[0] <= x_left;
			xr_s[0] <= x_right;
			for (int j = 1; j < MulIdx; j++) begin
				xl_s[j] <= xl_s[j-1];
				xr_s[j] <= xr_s[j-1];
			end
		end
	end

	// angle product, Q17.31
	always_ff @(posedge clk) begin
		if (en) red_s[0] <= {32'd0, position} * {16'd0, frequency};
	end

	// restoring reduction modulo 2*pi, one quotient bit per stage
	for (genvar k = 1; k <= rpe_pkg::RedSteps; k++) begin : g_red
		localparam logic [rpe_pkg::ProdW-1:0] Sub = rpe_pkg::TwoPiQ31 << (rpe_pkg::RedSteps - k);
		always_ff @(posedge clk) begin
			if (en) red_s[k] <= (red_s[k-1] >= Sub) ? red_s[k-1] - Sub : red_s[k-1];
		end
	end

	// halve to Q.30, center on zero, fold into [-pi/2, pi/2]
	logic signed [AW-1:0] fa, fb, fz;
	logic                 ff;
	always_comb begin
		fa = $signed({1'b0, red_s[rpe_pkg::RedSteps][AW-1:1]});
		fb = (fa >= rpe_pkg::PiQ30) ? fa - rpe_pkg::TwoPiQ30 : fa;
		fz = fb;
		ff = 1'b0;
		if (fb > rpe_pkg::HalfPiQ30) begin
			fz = fb - rpe_pkg::PiQ30;
			ff = 1'b1;
		end else if (fb < -rpe_pkg::HalfPiQ30) begin
			fz = fb + rpe_pkg::PiQ30;
			ff = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0]    <= fz;
			flip_s[0] <= ff;
		end
	end

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		logic signed [AW-1:0] cx, cy, dx, dy, at;
		if (i == 0) begin : g_first
			assign cx = rpe_pkg::GainQ30;
			assign cy = '0;
		end else begin : g_next
			assign cx = x_s[i];
			assign cy = y_s[i];
		end
		assign dx = cy >>> i;
		assign dy = cx >>> i;
		assign at = rpe_pkg::atan_q30(5'(i));
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][AW-1]) begin
					x_s[i+1] <= cx - dx;
					y_s[i+1] <= cy + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= cx + dx;
					y_s[i+1] <= cy - dy;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	logic signed [AW-1:0] cosv, sinv;
	assign cosv = flip_s[NC] ? -x_s[NC] : x_s[NC];
	assign sinv = flip_s[NC] ? -y_s[NC] : y_s[NC];

	logic signed [PW:0] rl, rr;
	assign rl = (accl_s + (PW+1)'(1 << 29)) >>> 30;
	assign rr = (accr_s + (PW+1)'(1 << 29)) >>> 30;

	function automatic logic signed [31:0] sat32(input logic signed [PW:0] v);
		if (v > (PW+1)'(64'sd2147483647)) return 32'sh7FFFFFFF;
		if (v < -(PW+1)'(64'sd2147483648)) return 32'sh80000000;
		return v[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s  <= PW'(xl_s[MulIdx-1]) * PW'(cosv);
			prs_s  <= PW'(xr_s[MulIdx-1]) * PW'(sinv);
			prc_s  <= PW'(xr_s[MulIdx-1]) * PW'(cosv);
			pls_s  <= PW'(xl_s[MulIdx-1]) * PW'(sinv);
			accl_s <= (PW+1)'(pll_s) - (PW+1)'(prs_s);
			accr_s <= (PW+1)'(prc_s) + (PW+1)'(pls_s);
			outl_s <= sat32(rl);
			outr_s <= sat32(rr);
		end
	end

endmodule

[dv/tb_top.sv]
// Testbench for rotary_position_embedding: directed table then random items.
// Predicts each rotated pair with a local CORDIC model; depends on the RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam int Stages     = 24;
	localparam int WatchLimit = 4000;
	localparam int NumRandom  = 650;

	typedef struct {
		logic [15:0]        pos;
		logic [31:0]        freq;
		logic signed [31:0] xl;
		logic signed [31:0] xr;
		bit                 has_exp;
		logic signed [31:0] el;
		logic signed [31:0] er;
	} row_t;

	typedef struct {
		logic signed [31:0] l;
		logic signed [31:0] r;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] position = '0;
	logic [31:0] frequency = '0;
	logic signed [31:0] x_left = '0;
	logic signed [31:0] x_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] out_left;
	logic signed [31:0] out_right;

	pair_t rotated_q[$];
	row_t  items[$];
	int    errors = 0;
	int    idle_cnt = 0;
	bit    calm = 1'b0;
	bit    drained = 1'b0;

	rotary_position_embedding #(.CORDIC_STAGES(Stages)) DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [31:0] round_clip(input logic signed [95:0] acc);
		logic signed [95:0] v;
		v = (acc + 96'sd536870912) >>> 30;
		if (v > 96'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -96'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic pair_t rotate_pair(input logic [15:0] p, input logic [31:0] f,
			input logic signed [31:0] xl, input logic signed [31:0] xr);
		logic [63:0] prod;
		logic signed [63:0] z, cx, cy, dx, dy, at;
		bit flip;
		pair_t res;
		prod = 64'(p) * 64'(f);
		z = $signed((prod % 64'd13493037705) >> 1);
		flip = 1'b0;
		if (z >= 64'sd3373259426)
			z = z - 64'sd6746518852;
		if (z > 64'sd1686629713) begin
			z = z - 64'sd3373259426;
			flip = 1'b1;
		end else if (z < -64'sd1686629713) begin
			z = z + 64'sd3373259426;
			flip = 1'b1;
		end
		cx = 64'sd652032874;
		cy = 0;
		for (int i = 0; i < Stages && i < 32; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			case (i)
				0: at = 64'h3243F6A8;   1: at = 64'h1DAC6705;   2: at = 64'h0FADBAFC;
				3: at = 64'h07F56EA6;   4: at = 64'h03FEAB76;   5: at = 64'h01FFD55B;
				6: at = 64'h00FFFAAA;   7: at = 64'h007FFF55;   8: at = 64'h003FFFEA;
				9: at = 64'h001FFFFD;   10: at = 64'h000FFFFF;  11: at = 64'h0007FFFF;
				12: at = 64'h0003FFFF;  13: at = 64'h0001FFFF;  14: at = 64'h0000FFFF;
				15: at = 64'h00007FFF;  16: at = 64'h00003FFF;  17: at = 64'h00001FFF;
				18: at = 64'h00000FFF;  19: at = 64'h000007FF;  20: at = 64'h000003FF;
				21: at = 64'h000001FF;  22: at = 64'h000000FF;  23: at = 64'h0000007F;
				24: at = 64'h0000003F;  25: at = 64'h0000001F;  26: at = 64'h0000000F;
				27: at = 64'h8;         28: at = 64'h4;         29: at = 64'h2;
				30: at = 64'h1;         default: at = 0;
			endcase
			if (z >= 0) begin
				cx = cx - dx;
				cy = cy + dy;
				z = z - at;
			end else begin
				cx = cx + dx;
				cy = cy - dy;
				z = z + at;
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		res.l = round_clip(96'(xl) * 96'(cx) - 96'(xr) * 96'(cy));
		res.r = round_clip(96'(xr) * 96'(cx) + 96'(xl) * 96'(cy));
		return res;
	endfunction

	function automatic row_t mk(input logic [15:0] p, input logic [31:0] f,
			input logic [31:0] xl, input logic [31:0] xr, input bit he = 1'b0,
			input logic [31:0] el = '0, input logic [31:0] er = '0);
		row_t r;
		r.pos = p; r.freq = f; r.xl = xl; r.xr = xr;
		r.has_exp = he; r.el = el; r.er = er;
		return r;
	endfunction

	function automatic logic [31:0] rand_x();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h80000000 | ($urandom & 32'h1);
			2: return 32'h7FFFFFFF - ($urandom & 32'h1);
			default: return 32'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh1FFFFF);
		endcase
	endfunction

	initial begin
		// zero angle and zero data give zero; everything else via predictor
		items.push_back(mk(16'd0, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0));
		items.push_back(mk(16'd5, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0));
		items.push_back(mk(16'd0, 32'd0, 32'h00010000, 32'h00000000));
		items.push_back(mk(16'd0, 32'd0, 32'h00000000, 32'h00010000));
		items.push_back(mk(16'hFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		items.push_back(mk(16'hFFFF, 32'h80000000, 32'h80000000, 32'h80000000));
		items.push_back(mk(16'd1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
		items.push_back(mk(16'd3, 32'h80000000, 32'h00010000, 32'hFFFF0000));
		items.push_back(mk(16'd2, 32'hC90FDAA2, 32'h00020000, 32'h00010000));
		items.push_back(mk(16'd1, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF));
		items.push_back(mk(16'd7, 32'h5555AAAA, 32'h7FFFFFFF, 32'h00000000));
		items.push_back(mk(16'd4, 32'hC90FDAA2, 32'h12345678, 32'h87654321));
		items.push_back(mk(16'h8000, 32'h00000001, 32'hFFFFFFFF, 32'h00000001));
		items.push_back(mk(16'h1234, 32'h6487ED51, 32'h55555555, 32'hAAAAAAAA));
		for (int i = 0; i < NumRandom; i++) begin
			logic [15:0] p;
			logic [31:0] f;
			p = (i % 4 == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
			f = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h80000000);
			items.push_back(mk(p, f, rand_x(), rand_x()));
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// sender
	initial begin
		int gap;
		int k;
		row_t r;
		pair_t e;
		k = 0;
		@(posedge clk iff arst_n);
		while (k < items.size()) begin
			if (k > items.size() - 60)
				calm = 1'b1;
			if (!calm && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				gap = $urandom_range(1, 18);
				repeat (gap) @(posedge clk);
			end
			r = items[k];
			in_valid <= 1'b1;
			position <= r.pos;
			frequency <= r.freq;
			x_left <= r.xl;
			x_right <= r.xr;
			@(posedge clk iff !in_stall);
			if (r.has_exp) begin
				e.l = r.el;
				e.r = r.er;
			end else begin
				e = rotate_pair(r.pos, r.freq, r.xl, r.xr);
			end
			rotated_q.push_back(e);
			k++;
		end
		in_valid <= 1'b0;
		drained = 1'b1;
	end

	// receiver stall bursts
	initial begin
		int gap;
		@(posedge clk iff arst_n);
		forever begin
			if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				gap = $urandom_range(1, 18);
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		pair_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (rotated_q.size() == 0) begin
					$error("unexpected item out_left=%0d out_right=%0d", out_left, out_right);
					errors++;
				end else begin
					e = rotated_q.pop_front();
					if (out_left !== e.l) begin
						$error("out_left expected %0d actual %0d", e.l, out_left);
						errors++;
					end
					if (out_right !== e.r) begin
						$error("out_right expected %0d actual %0d", e.r, out_right);
						errors++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
		end
	end

	initial begin
		@(posedge clk iff arst_n);
		fork
			begin
				wait (drained && rotated_q.size() == 0);
				repeat (Stages + 40) @(posedge clk);
			end
			begin
				wait (idle_cnt >= WatchLimit);
				errors++;
			end
		join_any
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[rotary_position_embedding.f]
rtl/rpe_pkg.sv
rtl/rotary_position_embedding.sv
dv/tb_top.sv
